@@ design/vk7bd_pkg.sv @@
// ----------------------------------------------------------------------------
// Viterbi K7 block decoder package
// Shared constants, metric types and the branch label function for the
// 64-state, rate one-half trellis.
// ----------------------------------------------------------------------------
package vk7bd_pkg;

   // Block configuration.
   localparam int SYMBOLS_PER_WORD = 16;
   localparam int METRIC_MAX       = 255;

   // Code and word geometry.
   localparam int NSTATES  = 64;
   localparam int STATE_W  = 6;
   localparam int WORD_W   = 32;
   localparam int DEC_W    = 16;
   localparam int SYM_W    = 2;
   localparam logic [STATE_W:0] GEN_A = 7'h79;
   localparam logic [STATE_W:0] GEN_B = 7'h5B;

   // Derived widths.
   localparam int METRIC_W = $clog2(METRIC_MAX + 1);
   localparam int STAGE_W  = (SYMBOLS_PER_WORD > 1) ? $clog2(SYMBOLS_PER_WORD) : 1;

   // Best-state search: eight metrics are examined per cycle.
   localparam int SRCH_LANES  = 8;
   localparam int SRCH_GROUPS = NSTATES / SRCH_LANES;
   localparam int LANE_W      = $clog2(SRCH_LANES);
   localparam int GRP_W       = $clog2(SRCH_GROUPS);

   typedef logic [METRIC_W-1:0]               metric_type;
   typedef logic [NSTATES-1:0][METRIC_W-1:0]  metric_vec_type;
   typedef logic [NSTATES-1:0]                decision_type;

   // Encoder output pair for a branch leaving predecessor state pred with
   // the given input bit. The upper bit belongs to the first generator.
   function automatic logic [SYM_W-1:0] expected_symbol(input logic [STATE_W-1:0] pred,
                                                        input logic in_bit);
      logic [STATE_W:0] shift_reg;
      shift_reg = {in_bit, pred};
      return {^(shift_reg & GEN_A), ^(shift_reg & GEN_B)};
   endfunction

endpackage

@@ design/vk7bd_acs_bank.sv @@
// ----------------------------------------------------------------------------
// Add-compare-select bank
// Sixty-four ACS lanes that advance every path metric by one trellis stage
// for one received symbol and report the survivor decision of each state.
// ----------------------------------------------------------------------------
module vk7bd_acs_bank (
   input  logic [vk7bd_pkg::SYM_W-1:0] symbol,
   input  vk7bd_pkg::metric_vec_type   pm,
   output vk7bd_pkg::metric_vec_type   pm_next,
   output vk7bd_pkg::decision_type     decision
);

   localparam logic [vk7bd_pkg::METRIC_W:0] METRIC_SAT =
      (vk7bd_pkg::METRIC_W + 1)'(vk7bd_pkg::METRIC_MAX);

   always_comb begin
      logic [vk7bd_pkg::STATE_W-1:0]  ns;
      logic [vk7bd_pkg::STATE_W-1:0]  p0;
      logic [vk7bd_pkg::STATE_W-1:0]  p1;
      logic [vk7bd_pkg::SYM_W-1:0]    x0;
      logic [vk7bd_pkg::SYM_W-1:0]    x1;
      logic [vk7bd_pkg::METRIC_W:0]   c0;
      logic [vk7bd_pkg::METRIC_W:0]   c1;
      for (int s = 0; s < vk7bd_pkg::NSTATES; s++) begin
         ns = vk7bd_pkg::STATE_W'(s);
         p0 = {ns[vk7bd_pkg::STATE_W-2:0], 1'b0};
         p1 = {ns[vk7bd_pkg::STATE_W-2:0], 1'b1};
         x0 = symbol ^ vk7bd_pkg::expected_symbol(p0, ns[vk7bd_pkg::STATE_W-1]);
         x1 = symbol ^ vk7bd_pkg::expected_symbol(p1, ns[vk7bd_pkg::STATE_W-1]);
         c0 = {1'b0, pm[p0]} + (vk7bd_pkg::METRIC_W + 1)'(x0[1])
                             + (vk7bd_pkg::METRIC_W + 1)'(x0[0]);
         c1 = {1'b0, pm[p1]} + (vk7bd_pkg::METRIC_W + 1)'(x1[1])
                             + (vk7bd_pkg::METRIC_W + 1)'(x1[0]);
         if (c0 > METRIC_SAT) begin
            c0 = METRIC_SAT;
         end
         if (c1 > METRIC_SAT) begin
            c1 = METRIC_SAT;
         end
         // On a tie the even predecessor survives.
         if (c0 <= c1) begin
            pm_next[s]  = c0[vk7bd_pkg::METRIC_W-1:0];
            decision[s] = 1'b0;
         end else begin
            pm_next[s]  = c1[vk7bd_pkg::METRIC_W-1:0];
            decision[s] = 1'b1;
         end
      end
   end

endmodule

@@ design/viterbi_k7_block_decoder.sv @@
// ----------------------------------------------------------------------------
// Viterbi K7 block decoder
// Hard-decision Viterbi decoder for the K=7, rate one-half code (generators
// 0x79 and 0x5B) that decodes one 32-bit word of sixteen symbols at a time.
// ----------------------------------------------------------------------------
// A word is taken on a rising edge with start high and busy low. It then
// runs an ACS step for each of its sixteen symbols, in which one shared bank
// of 64 ACS lanes advances the trellis by that symbol, then a best-state
// search that looks at eight path metrics per cycle, and sixteen traceback
// steps through the survivor memory, one stage per cycle. Busy stays high
// throughout. In the cycle after the last traceback step rsp_valid is high
// for exactly one cycle with the decoded word on rsp_decoded_bits; the
// receiver cannot stall the block, so it must capture the beat in that cycle.
// Busy is already low in that cycle, so the next word can be started there.
// Each word is decoded on its own: path metrics restart with state zero at 0
// and all others at 255, and nothing is carried between words.
// ----------------------------------------------------------------------------
module viterbi_k7_block_decoder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [vk7bd_pkg::WORD_W-1:0] req_encoded_word,
   output logic                         rsp_valid,
   output logic [vk7bd_pkg::DEC_W-1:0]  rsp_decoded_bits
);

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ACS   = 4'b0010,
      ST_SRCH  = 4'b0100,
      ST_TRACE = 4'b1000
   } seq_state_type;

   localparam logic [vk7bd_pkg::STAGE_W-1:0] LAST_STAGE =
      vk7bd_pkg::STAGE_W'(vk7bd_pkg::SYMBOLS_PER_WORD - 1);
   localparam logic [vk7bd_pkg::GRP_W-1:0] LAST_GRP =
      vk7bd_pkg::GRP_W'(vk7bd_pkg::SRCH_GROUPS - 1);
   localparam vk7bd_pkg::metric_type METRIC_INIT =
      vk7bd_pkg::METRIC_W'(vk7bd_pkg::METRIC_MAX);

   seq_state_type                       state_ff, state_in;
   logic [vk7bd_pkg::WORD_W-1:0]        word_ff, word_in;
   vk7bd_pkg::metric_vec_type           pm_ff, pm_in;
   logic [vk7bd_pkg::STAGE_W-1:0]       stage_ff, stage_in;
   logic [vk7bd_pkg::GRP_W-1:0]         grp_ff, grp_in;
   vk7bd_pkg::metric_type               best_pm_ff, best_pm_in;
   logic [vk7bd_pkg::STATE_W-1:0]       cur_ff, cur_in;
   logic [vk7bd_pkg::DEC_W-1:0]         dec_ff, dec_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [vk7bd_pkg::DEC_W-1:0]         rsp_data_ff, rsp_data_in;

   // Survivor memory: one row of 64 decision bits per trellis stage.
   vk7bd_pkg::decision_type             surv_ff [vk7bd_pkg::SYMBOLS_PER_WORD];

   vk7bd_pkg::metric_vec_type           acs_pm_next;
   vk7bd_pkg::decision_type             acs_decision;

   // Search datapath results.
   vk7bd_pkg::metric_type               lane_best_pm;
   logic [vk7bd_pkg::LANE_W-1:0]        lane_best_idx;
   logic                                srch_take;
   logic                                surv_bit;

   // The shared ACS bank works on the symbol at the top of the word register.
   vk7bd_acs_bank u_acs (
      .symbol   (word_ff[vk7bd_pkg::WORD_W-1 -: vk7bd_pkg::SYM_W]),
      .pm       (pm_ff),
      .pm_next  (acs_pm_next),
      .decision (acs_decision)
   );

   // Best of the eight metrics at the bottom of the metric register. A strict
   // compare keeps the lowest index on ties.
   always_comb begin
      lane_best_pm  = pm_ff[0];
      lane_best_idx = '0;
      for (int i = 1; i < vk7bd_pkg::SRCH_LANES; i++) begin
         if (pm_ff[i] < lane_best_pm) begin
            lane_best_pm  = pm_ff[i];
            lane_best_idx = vk7bd_pkg::LANE_W'(i);
         end
      end
   end

   // Earlier groups hold lower state numbers, so a later group wins only
   // with a strictly smaller metric.
   assign srch_take = (grp_ff == '0) || (lane_best_pm < best_pm_ff);

   // Decision bit of the current state at the current traceback stage.
   assign surv_bit = surv_ff[stage_ff][cur_ff];

   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      pm_in        = pm_ff;
      stage_in     = stage_ff;
      grp_in       = grp_ff;
      best_pm_in   = best_pm_ff;
      cur_in       = cur_ff;
      dec_in       = dec_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               word_in  = req_encoded_word;
               for (int s = 0; s < vk7bd_pkg::NSTATES; s++) begin
                  pm_in[s] = (s == 0) ? '0 : METRIC_INIT;
               end
               stage_in = '0;
               dec_in   = '0;
               state_in = ST_ACS;
            end
         end
         ST_ACS: begin
            pm_in    = acs_pm_next;
            word_in  = {word_ff[vk7bd_pkg::WORD_W-vk7bd_pkg::SYM_W-1:0],
                        {vk7bd_pkg::SYM_W{1'b0}}};
            stage_in = stage_ff + vk7bd_pkg::STAGE_W'(1);
            if (stage_ff == LAST_STAGE) begin
               grp_in   = '0;
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            // Rotate the metric register so the next group moves to the bottom.
            for (int i = 0; i < vk7bd_pkg::NSTATES; i++) begin
               pm_in[i] = pm_ff[(i + vk7bd_pkg::SRCH_LANES) % vk7bd_pkg::NSTATES];
            end
            if (srch_take) begin
               best_pm_in = lane_best_pm;
               cur_in     = {grp_ff, lane_best_idx};
            end
            grp_in = grp_ff + vk7bd_pkg::GRP_W'(1);
            if (grp_ff == LAST_GRP) begin
               stage_in = LAST_STAGE;
               state_in = ST_TRACE;
            end
         end
         ST_TRACE: begin
            // The decoded bit of a stage is the top bit of the state it enters.
            dec_in   = {dec_ff[vk7bd_pkg::DEC_W-2:0], cur_ff[vk7bd_pkg::STATE_W-1]};
            cur_in   = {cur_ff[vk7bd_pkg::STATE_W-2:0], surv_bit};
            stage_in = stage_ff - vk7bd_pkg::STAGE_W'(1);
            if (stage_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = dec_in;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      pm_ff       <= pm_in;
      stage_ff    <= stage_in;
      grp_ff      <= grp_in;
      best_pm_ff  <= best_pm_in;
      cur_ff      <= cur_in;
      dec_ff      <= dec_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_ACS) begin
         surv_ff[stage_ff] <= acs_decision;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_decoded_bits = rsp_data_ff;

endmodule

@@ design/vk7bd_checker.sv @@
// ----------------------------------------------------------------------------
// Viterbi K7 block decoder checker
// Port-level checks on the start/busy handshake and the result strobe.
// ----------------------------------------------------------------------------
module vk7bd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [vk7bd_pkg::WORD_W-1:0] req_encoded_word,
   input logic                         rsp_valid,
   input logic [vk7bd_pkg::DEC_W-1:0]  rsp_decoded_bits
);

   // Cycles from an accepted word to its result beat.
   localparam int LATENCY = 2 * vk7bd_pkg::SYMBOLS_PER_WORD + vk7bd_pkg::SRCH_GROUPS + 1;

   // An accepted word makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted word");

   // Each accepted word yields its result beat after a fixed latency.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("result beat missing at the expected cycle");

   // A result beat lasts one cycle and only appears while idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy ##1 !rsp_valid)
      else $error("result strobe longer than one cycle or seen while busy");

   // Finishing a word always delivers a beat.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy fell without a result beat");

   // Accepted words and result beats carry known values.
   assert property (@(posedge clock) disable iff (reset)
      !(start && !busy && $isunknown(req_encoded_word)) &&
      !(rsp_valid && $isunknown(rsp_decoded_bits)))
      else $error("unknown value on an accepted word or a result beat");

endmodule

bind viterbi_k7_block_decoder vk7bd_checker u_vk7bd_checker (.*);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Viterbi K7 block decoder testbench
// Sends 32-bit words of hard-decision symbols into the decoder and compares
// every decoded word with a behavioral trellis decoder run in the bench.
// ----------------------------------------------------------------------------
module tb;

   // The longest stretch of cycles in which neither a word is taken nor a
   // decoded word comes back. This is many times the longest decode plus the
   // longest sender gap, which is the slowest correct case.
   localparam int STALL_LIMIT = 2000;

   // Cycles to keep watching after the last decoded word has come back, so
   // that a stray extra strobe is still seen.
   localparam int DRAIN_CYCLES = 48;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [vk7bd_pkg::WORD_W-1:0]        req_encoded_word = '0;
   logic                                rsp_valid;
   logic [vk7bd_pkg::DEC_W-1:0]         rsp_decoded_bits;

   // One row of the directed table. When known is set, the decoded word is
   // typed in; otherwise the bench decoder supplies it.
   typedef struct {
      logic [vk7bd_pkg::WORD_W-1:0] word;
      bit                           known;
      logic [vk7bd_pkg::DEC_W-1:0]  decoded;
   } directed_row_type;

   logic [vk7bd_pkg::DEC_W-1:0] decoded_pending [$];
   int                          mismatch_count = 0;
   int                          idle_cycles = 0;
   int                          burst_left = 0;

   viterbi_k7_block_decoder uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_encoded_word (req_encoded_word),
      .rsp_valid        (rsp_valid),
      .rsp_decoded_bits (rsp_decoded_bits)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Output pair of the convolutional encoder for one branch. The shift
   // register holds the new input bit above the six bits of the old state;
   // the upper output bit belongs to the first generator.
   function automatic logic [vk7bd_pkg::SYM_W-1:0] encoder_outputs(
      input logic [vk7bd_pkg::STATE_W-1:0] from_state,
      input logic                          in_bit);
      logic [vk7bd_pkg::STATE_W:0] shifter;
      shifter = {in_bit, from_state};
      return {^(shifter & vk7bd_pkg::GEN_A), ^(shifter & vk7bd_pkg::GEN_B)};
   endfunction

   // Encodes a 16-bit message from the all-zero state. Bit t of the message
   // is the input of stage t and its symbol lands in the word with symbol 0
   // in the top two bits. Used to build well-formed words for the stimulus.
   function automatic logic [vk7bd_pkg::WORD_W-1:0] encode_message(
      input logic [vk7bd_pkg::DEC_W-1:0] message);
      logic [vk7bd_pkg::STATE_W-1:0] enc_state;
      logic [vk7bd_pkg::WORD_W-1:0]  word;
      enc_state = '0;
      word      = '0;
      for (int t = 0; t < vk7bd_pkg::SYMBOLS_PER_WORD; t++) begin
         word[vk7bd_pkg::WORD_W-1-vk7bd_pkg::SYM_W*t -: vk7bd_pkg::SYM_W] =
            encoder_outputs(enc_state, message[t]);
         enc_state = {message[t], enc_state[vk7bd_pkg::STATE_W-1:1]};
      end
      return word;
   endfunction

   // Behavioral decoder for one word. Path metrics start at zero for state
   // zero and at the ceiling elsewhere, saturate at the ceiling, and each
   // state keeps the even predecessor when the two candidates are equal.
   // The lowest-numbered state wins among equal final metrics, and the
   // survivor path from it is walked back one stage at a time.
   function automatic logic [vk7bd_pkg::DEC_W-1:0] viterbi_decode(
      input logic [vk7bd_pkg::WORD_W-1:0] word);
      vk7bd_pkg::metric_type         path_metric [vk7bd_pkg::NSTATES];
      vk7bd_pkg::metric_type         next_metric [vk7bd_pkg::NSTATES];
      vk7bd_pkg::decision_type       took_odd [vk7bd_pkg::SYMBOLS_PER_WORD];
      logic [vk7bd_pkg::SYM_W-1:0]   rx_sym;
      logic [vk7bd_pkg::STATE_W-1:0] to_state;
      logic [vk7bd_pkg::STATE_W-1:0] pred_even;
      logic [vk7bd_pkg::STATE_W-1:0] pred_odd;
      logic [vk7bd_pkg::STATE_W-1:0] win_state;
      logic [vk7bd_pkg::STATE_W-1:0] walk_state;
      int unsigned                   cand_even;
      int unsigned                   cand_odd;
      logic [vk7bd_pkg::DEC_W-1:0]   bits_out;

      for (int s = 0; s < vk7bd_pkg::NSTATES; s++)
         path_metric[s] = (s == 0) ? vk7bd_pkg::metric_type'(0)
                                   : vk7bd_pkg::metric_type'(vk7bd_pkg::METRIC_MAX);

      for (int t = 0; t < vk7bd_pkg::SYMBOLS_PER_WORD; t++) begin
         rx_sym      = word[vk7bd_pkg::WORD_W-1-vk7bd_pkg::SYM_W*t -: vk7bd_pkg::SYM_W];
         took_odd[t] = '0;
         for (int s = 0; s < vk7bd_pkg::NSTATES; s++) begin
            to_state  = vk7bd_pkg::STATE_W'(s);
            pred_even = {to_state[vk7bd_pkg::STATE_W-2:0], 1'b0};
            pred_odd  = {to_state[vk7bd_pkg::STATE_W-2:0], 1'b1};
            cand_even = 32'(path_metric[pred_even])
                      + 32'($countones(rx_sym ^ encoder_outputs(
                           pred_even, to_state[vk7bd_pkg::STATE_W-1])));
            cand_odd  = 32'(path_metric[pred_odd])
                      + 32'($countones(rx_sym ^ encoder_outputs(
                           pred_odd, to_state[vk7bd_pkg::STATE_W-1])));
            if (cand_even > vk7bd_pkg::METRIC_MAX)
               cand_even = vk7bd_pkg::METRIC_MAX;
            if (cand_odd > vk7bd_pkg::METRIC_MAX)
               cand_odd = vk7bd_pkg::METRIC_MAX;
            if (cand_even <= cand_odd) begin
               next_metric[s] = vk7bd_pkg::metric_type'(cand_even);
            end else begin
               next_metric[s] = vk7bd_pkg::metric_type'(cand_odd);
               took_odd[t][s] = 1'b1;
            end
         end
         path_metric = next_metric;
      end

      win_state = '0;
      for (int s = 1; s < vk7bd_pkg::NSTATES; s++)
         if (path_metric[s] < path_metric[win_state])
            win_state = vk7bd_pkg::STATE_W'(s);

      bits_out   = '0;
      walk_state = win_state;
      for (int t = vk7bd_pkg::SYMBOLS_PER_WORD - 1; t >= 0; t--) begin
         bits_out[t] = walk_state[vk7bd_pkg::STATE_W-1];
         walk_state  = {walk_state[vk7bd_pkg::STATE_W-2:0], took_odd[t][walk_state]};
      end
      return bits_out;
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [vk7bd_pkg::DEC_W-1:0] got,
                                  input logic [vk7bd_pkg::DEC_W-1:0] want);
      $display("tb: mismatch at %0t: %s: got %h, expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Sender pacing. Words go out in bursts of random length; before each
   // burst the sender may sit idle for a random number of cycles. About a
   // quarter of the bursts start with no gap at all, so long runs with start
   // held high occur too. The gaps land on every phase of the decode.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // Offers one word and holds it until the decoder takes it, which is the
   // first rising edge with start high and busy low. Called right after a
   // rising edge; returns right after the edge that took the beat, so the
   // next word can follow with start left high.
   task automatic offer_word(input logic [vk7bd_pkg::WORD_W-1:0] word, input bit known,
                             input logic [vk7bd_pkg::DEC_W-1:0] decoded);
      start            <= 1'b1;
      req_encoded_word <= word;
      do @(posedge clock); while (busy);
      decoded_pending.push_back(known ? decoded : viterbi_decode(word));
   endtask

   // Lowers start and waits until every decoded word still owed has come
   // back, so the decoder runs dry between phases.
   task automatic drain_decoder();
      start <= 1'b0;
      @(posedge clock);
      while (decoded_pending.size() != 0)
         @(posedge clock);
   endtask

   // Result checker. The decoder holds rsp_valid for a single cycle and the
   // bench must take the beat on the edge that ends it. Values are read in
   // the active region of the edge, before the decoder's own updates land.
   always @(posedge clock) begin : check_result
      logic [vk7bd_pkg::DEC_W-1:0] want;
      if (!reset && rsp_valid) begin
         if (decoded_pending.size() == 0) begin
            report_mismatch("decoded word with none outstanding", rsp_decoded_bits, '0);
         end else begin
            want = decoded_pending.pop_front();
            if (rsp_decoded_bits !== want)
               report_mismatch("decoded result", rsp_decoded_bits, want);
         end
      end
   end

   // Watchdog: counts cycles in which no beat moves on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: watchdog expired at %0t", $realtime);
            $display("tb: FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      directed_row_type             directed_rows [$];
      logic [vk7bd_pkg::WORD_W-1:0] word;
      logic [vk7bd_pkg::WORD_W-1:0] clean;
      logic [vk7bd_pkg::DEC_W-1:0]  message;
      int                           flips;

      // Directed table. Rows whose answer is obvious carry it: the all-zero
      // word decodes to zero, and an error-free codeword decodes to its own
      // message, since no other path matches every symbol. The rest cover
      // the field extremes, alternating symbols, a flipped first and last
      // symbol, ties between equal metrics and saturation of the metrics
      // that start at the ceiling; those go through the bench decoder.
      directed_rows.push_back('{32'h0000_0000, 1'b1, 16'h0000});
      directed_rows.push_back('{32'hFFFF_FFFF, 1'b0, '0});
      directed_rows.push_back('{32'hAAAA_AAAA, 1'b0, '0});
      directed_rows.push_back('{32'h5555_5555, 1'b0, '0});
      directed_rows.push_back('{32'h8000_0000, 1'b0, '0});
      directed_rows.push_back('{32'hC000_0000, 1'b0, '0});
      directed_rows.push_back('{32'h0000_0001, 1'b0, '0});
      directed_rows.push_back('{32'h0000_0003, 1'b0, '0});
      directed_rows.push_back('{32'h3333_3333, 1'b0, '0});
      directed_rows.push_back('{32'hCCCC_CCCC, 1'b0, '0});
      directed_rows.push_back('{32'h0F0F_0F0F, 1'b0, '0});
      directed_rows.push_back('{32'hF0F0_F0F0, 1'b0, '0});
      directed_rows.push_back('{encode_message(16'hFFFF), 1'b1, 16'hFFFF});
      directed_rows.push_back('{encode_message(16'h0001), 1'b1, 16'h0001});
      directed_rows.push_back('{encode_message(16'h8000), 1'b1, 16'h8000});
      directed_rows.push_back('{encode_message(16'hA5C3), 1'b1, 16'hA5C3});
      directed_rows.push_back('{encode_message(16'h5555), 1'b1, 16'h5555});
      directed_rows.push_back('{encode_message(16'hFFFF) ^ 32'h0000_0001, 1'b0, '0});
      directed_rows.push_back('{encode_message(16'h1234) ^ 32'h0040_0000, 1'b0, '0});
      directed_rows.push_back('{encode_message(16'hBEEF) ^ 32'hC000_0003, 1'b0, '0});
      directed_rows.push_back('{encode_message(16'h7E81) ^ 32'h000F_0000, 1'b0, '0});

      // Reset is held high from time zero and released on a rising edge.
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         pace_sender();
         offer_word(directed_rows[i].word, directed_rows[i].known,
                    directed_rows[i].decoded);
      end

      // Let the decoder run dry once before the random part.
      drain_decoder();

      // Random part. Most words are codewords of random messages with a few
      // channel errors, so the survivor paths carry real structure and the
      // traceback is exercised well. The rest are short error bursts on a
      // codeword and plain noise words, which produce many metric ties.
      for (int n = 0; n < 1950; n++) begin
         message = (n % 97 == 0)
                 ? vk7bd_pkg::DEC_W'($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                 : vk7bd_pkg::DEC_W'($urandom_range(0, 65535));
         clean   = encode_message(message);
         case ($urandom_range(0, 9))
            0, 1: begin
               word = $urandom();
            end
            2: begin
               word = clean ^ (vk7bd_pkg::WORD_W'($urandom_range(1, 255))
                               << $urandom_range(0, 24));
            end
            default: begin
               word  = clean;
               flips = $urandom_range(0, 4);
               repeat (flips)
                  word[$urandom_range(0, vk7bd_pkg::WORD_W - 1)] ^= 1'b1;
            end
         endcase

         pace_sender();
         offer_word(word, 1'b0, '0);

         // Now and then the sender holds off until everything is back.
         if (n % 250 == 249) begin
            drain_decoder();
            burst_left = 0;
         end
      end

      drain_decoder();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

@@ viterbi_k7_block_decoder.f @@
design/vk7bd_pkg.sv
design/vk7bd_acs_bank.sv
design/viterbi_k7_block_decoder.sv
design/vk7bd_checker.sv
tb/tb.sv
